>>> rtl/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, character codes and the base64 alphabet for the line-wrapped
// base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

  // ASCII codes
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_PAD = 8'h3D;

  // Line length register reset value (19 groups = 76 characters)
  localparam logic [4:0] GPL_RESET = 5'd19;

  // Output step codes: CR, LF, then the four symbols of a group
  localparam logic [2:0] STEP_CR = 3'd0;
  localparam logic [2:0] STEP_LF = 3'd1;
  localparam logic [2:0] STEP_C0 = 3'd2;
  localparam logic [2:0] STEP_C1 = 3'd3;
  localparam logic [2:0] STEP_C2 = 3'd4;
  localparam logic [2:0] STEP_C3 = 3'd5;

  // One classified group, as queued between front and back
  typedef struct packed {
    logic            crlf;   // emit CR LF before the group
    logic [3:0][7:0] chars;  // chars[0] leaves first
  } entry_t;

  // Map a 6-bit value to its base64 symbol
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] w;
    logic [7:0] c;
    w = {2'b00, v};
    if (v < 6'd26) begin
      c = w + 8'd65;
    end else if (v < 6'd52) begin
      c = w + 8'd71;
    end else if (v < 6'd62) begin
      c = w - 8'd4;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

>>> rtl/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Accepts byte groups, encodes them into four characters and decides whether
// a line break goes ahead of the group. Holds the line length register and
// the groups-on-line counter.
// ----------------------------------------------------------------------------
module b64e_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_first_byte,
  input  logic [7:0]         in_second_byte,
  input  logic [7:0]         in_third_byte,
  input  logic [1:0]         in_byte_count,
  input  logic               in_ends_stream,
  input  logic               q_full,
  output logic               q_push,
  output b64e_pkg::entry_t   q_entry
);

  logic [4:0] gpl_r;
  logic [4:0] gol_r, gol_nxt;
  logic       has2, has3, brk;
  logic [7:0] b1, b2;
  logic [5:0] s0, s1, s2, s3;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Mask unused bytes and split into sextets
  always_comb begin
    has2 = (in_byte_count == 2'd2) || (in_byte_count == 2'd3);
    has3 = (in_byte_count == 2'd3);
    b1   = has2 ? in_second_byte : 8'd0;
    b2   = has3 ? in_third_byte  : 8'd0;
    s0   = in_first_byte[7:2];
    s1   = {in_first_byte[1:0], b1[7:4]};
    s2   = {b1[3:0], b2[7:6]};
    s3   = b2[5:0];
    brk  = (gol_r >= gpl_r);
  end

  // Build the queue entry
  always_comb begin
    q_entry.crlf     = brk;
    q_entry.chars[0] = b64e_pkg::b64_char(s0);
    q_entry.chars[1] = b64e_pkg::b64_char(s1);
    q_entry.chars[2] = has2 ? b64e_pkg::b64_char(s2) : b64e_pkg::CHAR_PAD;
    q_entry.chars[3] = has3 ? b64e_pkg::b64_char(s3) : b64e_pkg::CHAR_PAD;
  end

  // Advance the line counter; restart at one after a break, clear at end of stream
  always_comb begin
    gol_nxt = gol_r;
    if (q_push) begin
      if (in_ends_stream) begin
        gol_nxt = 5'd0;
      end else if (brk) begin
        gol_nxt = 5'd1;
      end else begin
        gol_nxt = gol_r + 5'd1;
      end
    end
  end

  // Hold configuration and counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gpl_r <= b64e_pkg::GPL_RESET;
      gol_r <= 5'd0;
    end else begin
      gol_r <= gol_nxt;
      if (cfg_we) begin
        gpl_r <= cfg_wdata;
      end
    end
  end

endmodule

>>> rtl/b64e_fifo.sv
// ----------------------------------------------------------------------------
// b64e_fifo
// Short queue of classified groups between the front and the back.
// ----------------------------------------------------------------------------
module b64e_fifo #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  b64e_pkg::entry_t push_entry,
  input  logic             pop,
  output b64e_pkg::entry_t head,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  b64e_pkg::entry_t mem [DEPTH];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = mem[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Write storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= push_entry;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == LAST_PTR) ? '0 : wptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == LAST_PTR) ? '0 : rptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Serializes queued groups, one character per transfer, with an optional
// CR LF ahead of the four symbols. Drives the registered output channel.
// ----------------------------------------------------------------------------
module b64e_back (
  input  logic             clk,
  input  logic             rst_n,
  input  b64e_pkg::entry_t q_head,
  input  logic             q_empty,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_char,
  output logic             out_run_last
);

  b64e_pkg::entry_t ent_r;
  logic             busy_r, busy_nxt;
  logic [2:0]       step_r, step_nxt;
  logic             ov_r, ov_nxt;
  logic [7:0]       char_r;
  logic             last_r;
  logic             adv, emit, load, at_end;
  logic [7:0]       cur_char;
  logic [2:0]       first_step;

  assign out_valid    = ov_r;
  assign out_char     = char_r;
  assign out_run_last = last_r;

  // Pick the character for the current step
  always_comb begin
    case (step_r)
      b64e_pkg::STEP_CR: cur_char = b64e_pkg::CHAR_CR;
      b64e_pkg::STEP_LF: cur_char = b64e_pkg::CHAR_LF;
      b64e_pkg::STEP_C0: cur_char = ent_r.chars[0];
      b64e_pkg::STEP_C1: cur_char = ent_r.chars[1];
      b64e_pkg::STEP_C2: cur_char = ent_r.chars[2];
      b64e_pkg::STEP_C3: cur_char = ent_r.chars[3];
      default:           cur_char = ent_r.chars[3];
    endcase
  end

  // Sequence control: emit when the output register frees up, load the next
  // group on the last character or when idle
  always_comb begin
    adv        = !ov_r || out_ready;
    emit       = adv && busy_r;
    at_end     = (step_r == b64e_pkg::STEP_C3);
    load       = !q_empty && (!busy_r || (emit && at_end));
    q_pop      = load;
    first_step = q_head.crlf ? b64e_pkg::STEP_CR : b64e_pkg::STEP_C0;
    busy_nxt   = busy_r;
    step_nxt   = step_r;
    if (load) begin
      busy_nxt = 1'b1;
      step_nxt = first_step;
    end else if (emit) begin
      if (at_end) begin
        busy_nxt = 1'b0;
      end else begin
        step_nxt = step_r + 3'd1;
      end
    end
    ov_nxt = ov_r;
    if (adv) begin
      ov_nxt = emit;
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= b64e_pkg::STEP_CR;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      ov_r   <= ov_nxt;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    if (load) begin
      ent_r <= q_head;
    end
    if (emit) begin
      char_r <= cur_char;
      last_r <= at_end;
    end
  end

endmodule

>>> rtl/base64_line_wrapped_encoder.sv
// ----------------------------------------------------------------------------
// base64_line_wrapped_encoder
// Base64 encoder with CR LF line wrapping after a set number of groups.
//
//   channel  dir  handshake          payload
//   in       in   in_valid/ready     first/second/third byte, count, end
//   out      out  out_valid/ready    out_char, out_run_last
//   cfg      in   cfg_we             cfg_wdata = groups per line
//
// Each group leaves as 4 characters, or 6 with a leading CR LF, one per
// cycle while out_ready holds. When idle, a taken group passes the queue,
// the group register and the output register before out_valid rises.
// Reset is synchronous, active low; groups per line resets to 19.
// The front keeps taking groups while the queue has room, so a stalled
// output backs up the input once QUEUE_DEPTH groups wait in the queue
// behind the group being serialized.
// ----------------------------------------------------------------------------
module base64_line_wrapped_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_first_byte,
  input  logic [7:0] in_second_byte,
  input  logic [7:0] in_third_byte,
  input  logic [1:0] in_byte_count,
  input  logic       in_ends_stream,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_run_last
);

  b64e_pkg::entry_t push_entry;
  b64e_pkg::entry_t head;
  logic             push, pop, full, empty;

  // Accept and classify groups
  b64e_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_first_byte  (in_first_byte),
    .in_second_byte (in_second_byte),
    .in_third_byte  (in_third_byte),
    .in_byte_count  (in_byte_count),
    .in_ends_stream (in_ends_stream),
    .q_full         (full),
    .q_push         (push),
    .q_entry        (push_entry)
  );

  // Queue between front and back
  b64e_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (full),
    .empty      (empty)
  );

  // Serialize characters
  b64e_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_head       (head),
    .q_empty      (empty),
    .q_pop        (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .out_run_last (out_run_last)
  );

endmodule
